// ===== hdl/assert_macros.svh =====
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while reset is released
`define SKF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// checked on every edge, reset included
`define SKF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== hdl/skf_pkg.sv =====
// shared widths, item and result types and saturating arithmetic helpers
// no dependencies
package skf_pkg;

  localparam int DW = 32;          // signed data width
  localparam int FB = 20;          // fraction bits
  localparam int VW = DW - 1;      // unsigned variance width
  localparam int QB = DW + 1;      // quotient bits of the long division
  localparam int NW = 2 * DW;      // full product width
  localparam int SW = DW + 3;      // headroom for saturating sums
  localparam int CW = 8;           // component index width on the ports
  localparam int MAX_COMP_DEF = 256;
  localparam int MID_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  localparam logic [VW-1:0] TAU2_RESET = VW'(1048576);
  localparam logic [VW-1:0] VMAX = '1;
  localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic [CW-1:0]          comp;
    logic                   is_pair;
    logic signed [DW-1:0]   g11;
    logic signed [DW-1:0]   g12;
    logic [VW-1:0]          spec;
    logic                   first;
    logic signed [DW-1:0]   w1;
    logic signed [DW-1:0]   w2;
  } item_t;

  typedef struct packed {
    logic [CW-1:0]          comp;
    logic signed [DW-1:0]   pm1;
    logic signed [DW-1:0]   pm2;
    logic [VW-1:0]          pv;
    logic signed [DW-1:0]   fm1;
    logic signed [DW-1:0]   fm2;
    logic [VW-1:0]          fv;
  } res_t;

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] a);
    return a[DW-1] ? ((~$unsigned(a)) + DW'(1)) : $unsigned(a);
  endfunction

  function automatic logic signed [SW-1:0] sx(input logic signed [DW-1:0] a);
    return $signed({{(SW-DW){a[DW-1]}}, a});
  endfunction

  function automatic logic signed [SW-1:0] ux(input logic [QB-1:0] m);
    return $signed({{(SW-QB){1'b0}}, m});
  endfunction

  function automatic logic signed [DW-1:0] sat_wide(input logic signed [SW-1:0] s);
    if (s > sx(SMAX)) return SMAX;
    if (s < sx(SMIN)) return SMIN;
    return $signed(s[DW-1:0]);
  endfunction

  // product magnitude scaled back and clamped to the variance range
  function automatic logic [VW-1:0] umul_sat(input logic [NW-1:0] p);
    logic [NW-1:0] s;
    s = p >> FB;
    return (s > NW'(VMAX)) ? VMAX : s[VW-1:0];
  endfunction

  // product magnitude scaled back, signed and clamped
  function automatic logic signed [DW-1:0] smul_sat(input logic neg,
                                                    input logic [NW-1:0] p);
    logic [NW-1:0] m;
    logic [NW-1:0] lim;
    m = p >> FB;
    lim = neg ? (NW'(1) << (DW-1)) : ((NW'(1) << (DW-1)) - NW'(1));
    if (m > lim) return neg ? SMIN : SMAX;
    return neg ? -$signed(m[DW-1:0]) : $signed(m[DW-1:0]);
  endfunction

endpackage

// ===== hdl/skf_queue.sv =====
// small synchronous queue with registered count
// depends on nothing but its type parameter
module skf_queue #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int AW = $clog2(DEPTH);

  T                mem [DEPTH];
  logic [AW-1:0]   wr_q, rd_q;
  logic [AW:0]     cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + AW'(1);
      if (do_pop) rd_q <= rd_q + AW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + (AW+1)'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - (AW+1)'(1);
    end
  end

endmodule

// ===== hdl/skf_front.sv =====
// front end: takes input transfers, drops out-of-range components, queues items
// depends on skf_pkg and skf_queue
module skf_front import skf_pkg::*; #(
  parameter int MAX_COMPONENTS = MAX_COMP_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic                 operation_i,
  input  logic [CW-1:0]        component_i,
  input  logic                 is_pair_i,
  input  logic signed [DW-1:0] coef_damp_cos_i,
  input  logic signed [DW-1:0] coef_damp_sin_i,
  input  logic [VW-1:0]        coef_spectrum_i,
  input  logic                 first_step_i,
  input  logic signed [DW-1:0] obs_first_i,
  input  logic signed [DW-1:0] obs_second_i,
  output item_t                head_o,
  output logic                 head_valid_o,
  input  logic                 head_pop_i
);

  item_t item;
  logic  in_range;
  logic  q_empty;

  assign in_range = int'(component_i) < MAX_COMPONENTS;

  always_comb begin
    item.op      = op_e'(operation_i);
    item.comp    = component_i;
    item.is_pair = is_pair_i;
    item.g11     = coef_damp_cos_i;
    item.g12     = coef_damp_sin_i;
    item.spec    = coef_spectrum_i;
    item.first   = first_step_i;
    item.w1      = obs_first_i;
    item.w2      = obs_second_i;
  end

  // an out-of-range item is taken and dropped here
  skf_queue #(.T(item_t), .DEPTH(MID_DEPTH)) u_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && in_range),
    .data_i  (item),
    .full_o  (full),
    .pop_i   (head_pop_i),
    .data_o  (head_o),
    .empty_o (q_empty)
  );

  assign head_valid_o = !q_empty;

endmodule

// ===== hdl/skf_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on skf_pkg
module skf_div import skf_pkg::*; (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QB-1:0] quo_o
);

  // quotient is known to fit in QB bits, so the top bits start below den
  logic [DW-1:0] rem_q [QB];
  logic [QB-1:0] nq_q  [QB];
  logic [DW-1:0] den_q [QB];
  logic [DW-1:0] rin   [QB];
  logic [QB-1:0] nin   [QB];
  logic [DW-1:0] din   [QB];
  logic [DW-1:0] rem_d [QB];
  logic [QB-1:0] nq_d  [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign rin[k] = DW'(num_i[NW-1:QB]);
      assign nin[k] = num_i[QB-1:0];
      assign din[k] = den_i;
    end else begin : g_next
      assign rin[k] = rem_q[k-1];
      assign nin[k] = nq_q[k-1];
      assign din[k] = den_q[k-1];
    end
  end

  always_comb begin
    logic [DW:0] sh;
    logic [DW:0] df;
    logic        ge;
    for (int k = 0; k < QB; k++) begin
      sh = {rin[k], nin[k][QB-1]};
      df = sh - {1'b0, din[k]};
      ge = sh >= {1'b0, din[k]};
      rem_d[k] = ge ? df[DW-1:0] : sh[DW-1:0];
      nq_d[k]  = {nin[k][QB-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      nq_q  <= nq_d;
      den_q <= din;
    end
  end

  assign quo_o = nq_q[QB-1];

endmodule

// ===== hdl/skf_back.sv =====
// back end: coefficient and state memories, predict/update pipeline, writeback
// depends on skf_pkg and skf_div
module skf_back import skf_pkg::*; #(
  parameter int MAX_COMPONENTS = MAX_COMP_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          tau2_we_i,
  input  logic [VW-1:0] tau2_i,
  input  item_t         head_i,
  input  logic          head_valid_i,
  output logic          head_pop_o,
  input  logic          res_full_i,
  output logic          res_valid_o,
  output res_t          res_o
);

  localparam int AW = $clog2(MAX_COMPONENTS);

  typedef struct packed {
    logic [CW-1:0]        comp;
    logic signed [DW-1:0] p1;
    logic signed [DW-1:0] p2;
    logic [VW-1:0]        r1;
    logic                 neg1;
    logic                 neg2;
    logic                 dz;
  } fin_t;

  logic signed [DW-1:0] cos_mem [MAX_COMPONENTS];
  logic signed [DW-1:0] sin_mem [MAX_COMPONENTS];
  logic [VW-1:0]        spec_mem [MAX_COMPONENTS];
  logic                 pair_mem [MAX_COMPONENTS];
  logic signed [DW-1:0] m1_mem [MAX_COMPONENTS];
  logic signed [DW-1:0] m2_mem [MAX_COMPONENTS];
  logic [VW-1:0]        var_mem [MAX_COMPONENTS];

  logic [VW-1:0]             tau2_q;
  logic [MAX_COMPONENTS-1:0] busy_q, busy_d;
  logic                      v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic [QB-1:0]             dv_q;

  logic          en, blocked, issue, ld_we, st_issue, wb;
  logic [AW-1:0] ia, wa;

  // stage 1: memory read data
  logic signed [DW-1:0] rd_cos_q, rd_sin_q, rd_m1_q, rd_m2_q;
  logic [VW-1:0]        rd_spec_q, rd_var_q;
  logic                 rd_pair_q, s1_first_q;
  logic [CW-1:0]        s1_comp_q;
  logic signed [DW-1:0] s1_w1_q, s1_w2_q;

  // stage 2: raw products
  logic [NW-1:0]        s2_sq11_q, s2_sq12_q, s2_pa_q, s2_pb_q, s2_pc_q, s2_pd_q;
  logic                 s2_na_q, s2_nb_q, s2_nc_q, s2_nd_q, s2_pair_q;
  logic [VW-1:0]        s2_r_q, s2_spec_q;
  logic signed [DW-1:0] s2_w1_q, s2_w2_q;
  logic [CW-1:0]        s2_comp_q;

  // stage 3: scaled terms
  logic [VW-1:0]        s3_gsq_q, s3_r_q, s3_spec_q;
  logic signed [DW-1:0] s3_sa_q, s3_sb_q, s3_sc_q, s3_sd_q, s3_w1_q, s3_w2_q;
  logic [CW-1:0]        s3_comp_q;

  // stage 4: variance product and predicted means
  logic [NW-1:0]        s4_rp_q;
  logic [VW-1:0]        s4_spec_q;
  logic signed [DW-1:0] s4_p1_q, s4_p2_q, s4_w1_q, s4_w2_q;
  logic [CW-1:0]        s4_comp_q;

  // stage 5: predicted variance
  logic [VW-1:0]        s5_r1_q;
  logic signed [DW-1:0] s5_p1_q, s5_p2_q, s5_w1_q, s5_w2_q;
  logic [CW-1:0]        s5_comp_q;

  // stage 6: denominator and innovations
  logic [DW-1:0]        s6_den_q;
  logic [QB-1:0]        s6_d1_q, s6_d2_q;
  fin_t                 s6_side_q;

  // stage 7: division operands
  logic [NW-1:0]        s7_n1_q, s7_n2_q, s7_nv_q;
  logic [DW-1:0]        s7_den_q;
  fin_t                 s7_side_q;

  fin_t                 side_q [QB];
  logic [QB-1:0]        q1, q2, qv;

  assign en         = !res_full_i;
  assign ia         = AW'(head_i.comp);
  assign blocked    = (head_i.op == OP_STEP) && busy_q[ia];
  assign issue      = head_valid_i && en && !blocked;
  assign head_pop_o = issue;
  assign ld_we      = issue && (head_i.op == OP_LOAD);
  assign st_issue   = issue && (head_i.op == OP_STEP);
  assign wb         = en && dv_q[QB-1];
  assign wa         = AW'(side_q[QB-1].comp);

  always_comb begin
    busy_d = busy_q;
    if (wb) busy_d[wa] = 1'b0;
    if (st_issue) busy_d[ia] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tau2_q <= TAU2_RESET;
      busy_q <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      v7_q   <= 1'b0;
      dv_q   <= '0;
    end else begin
      if (tau2_we_i) tau2_q <= tau2_i;
      busy_q <= busy_d;
      if (en) begin
        v1_q <= st_issue;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
        v5_q <= v4_q;
        v6_q <= v5_q;
        v7_q <= v6_q;
        dv_q <= {dv_q[QB-2:0], v7_q};
      end
    end
  end

  // memories: loads write at issue, steps read at issue and write back at the end
  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      cos_mem[ia]  <= head_i.g11;
      sin_mem[ia]  <= head_i.g12;
      spec_mem[ia] <= head_i.spec;
      pair_mem[ia] <= head_i.is_pair;
    end
    if (wb) begin
      m1_mem[wa]  <= res_o.fm1;
      m2_mem[wa]  <= res_o.fm2;
      var_mem[wa] <= res_o.fv;
    end
    if (st_issue) begin
      rd_cos_q   <= cos_mem[ia];
      rd_sin_q   <= sin_mem[ia];
      rd_spec_q  <= spec_mem[ia];
      rd_pair_q  <= pair_mem[ia];
      rd_m1_q    <= m1_mem[ia];
      rd_m2_q    <= m2_mem[ia];
      rd_var_q   <= var_mem[ia];
      s1_first_q <= head_i.first;
      s1_comp_q  <= head_i.comp;
      s1_w1_q    <= head_i.w1;
      s1_w2_q    <= head_i.w2;
    end
  end

  // stage 2 operands
  logic signed [DW-1:0] g11, g12, ma, mb;
  logic [DW-1:0]        a11, a12, ama, amb;

  always_comb begin
    g11 = rd_cos_q;
    g12 = rd_pair_q ? rd_sin_q : '0;
    ma  = s1_first_q ? '0 : rd_m1_q;
    mb  = (s1_first_q || !rd_pair_q) ? '0 : rd_m2_q;
    a11 = mag(g11);
    a12 = mag(g12);
    ama = mag(ma);
    amb = mag(mb);
  end

  logic [DW-1:0]        gsum;
  logic [NW-1:0]        r1_wide;
  logic [VW-1:0]        r1_sat;
  logic signed [SW-1:0] df1, df2;
  logic signed [SW-1:0] ad1, ad2;

  always_comb begin
    gsum    = DW'(umul_sat(s2_sq11_q)) + DW'(umul_sat(s2_sq12_q));
    r1_wide = (s4_rp_q >> FB) + NW'(s4_spec_q);
    r1_sat  = (r1_wide > NW'(VMAX)) ? VMAX : r1_wide[VW-1:0];
    df1     = sx(s5_w1_q) - sx(s5_p1_q);
    df2     = sx(s5_w2_q) - sx(s5_p2_q);
    ad1     = df1[SW-1] ? -df1 : df1;
    ad2     = df2[SW-1] ? -df2 : df2;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_sq11_q <= a11 * a11;
      s2_sq12_q <= a12 * a12;
      s2_pa_q   <= a11 * ama;
      s2_pb_q   <= a12 * amb;
      s2_pc_q   <= a11 * amb;
      s2_pd_q   <= a12 * ama;
      s2_na_q   <= g11[DW-1] ^ ma[DW-1];
      s2_nb_q   <= g12[DW-1] ^ mb[DW-1];
      s2_nc_q   <= g11[DW-1] ^ mb[DW-1];
      s2_nd_q   <= g12[DW-1] ^ ma[DW-1];
      s2_pair_q <= rd_pair_q;
      s2_r_q    <= s1_first_q ? rd_spec_q : rd_var_q;
      s2_spec_q <= rd_spec_q;
      s2_w1_q   <= s1_w1_q;
      s2_w2_q   <= rd_pair_q ? s1_w2_q : '0;
      s2_comp_q <= s1_comp_q;

      s3_gsq_q  <= (gsum > DW'(VMAX)) ? VMAX : gsum[VW-1:0];
      s3_sa_q   <= smul_sat(s2_na_q, s2_pa_q);
      s3_sb_q   <= smul_sat(s2_nb_q, s2_pb_q);
      s3_sc_q   <= smul_sat(s2_nc_q, s2_pc_q);
      s3_sd_q   <= smul_sat(s2_nd_q, s2_pd_q);
      s3_r_q    <= s2_r_q;
      s3_spec_q <= s2_spec_q;
      s3_w1_q   <= s2_w1_q;
      s3_w2_q   <= s2_w2_q;
      s3_comp_q <= s2_comp_q;

      s4_rp_q   <= s3_r_q * s3_gsq_q;
      s4_p1_q   <= sat_wide(sx(s3_sa_q) + sx(s3_sb_q));
      s4_p2_q   <= sat_wide(sx(s3_sc_q) - sx(s3_sd_q));
      s4_spec_q <= s3_spec_q;
      s4_w1_q   <= s3_w1_q;
      s4_w2_q   <= s3_w2_q;
      s4_comp_q <= s3_comp_q;

      s5_r1_q   <= r1_sat;
      s5_p1_q   <= s4_p1_q;
      s5_p2_q   <= s4_p2_q;
      s5_w1_q   <= s4_w1_q;
      s5_w2_q   <= s4_w2_q;
      s5_comp_q <= s4_comp_q;

      s6_den_q       <= {1'b0, tau2_q} + {1'b0, s5_r1_q};
      s6_d1_q        <= ad1[QB-1:0];
      s6_d2_q        <= ad2[QB-1:0];
      s6_side_q.comp <= s5_comp_q;
      s6_side_q.p1   <= s5_p1_q;
      s6_side_q.p2   <= s5_p2_q;
      s6_side_q.r1   <= s5_r1_q;
      s6_side_q.neg1 <= df1[SW-1];
      s6_side_q.neg2 <= df2[SW-1];
      // the sum cannot wrap, so it is zero only when both terms are
      s6_side_q.dz   <= (tau2_q == '0) && (s5_r1_q == '0);

      s7_n1_q      <= s6_side_q.r1 * s6_d1_q;
      s7_n2_q      <= s6_side_q.r1 * s6_d2_q;
      s7_nv_q      <= s6_side_q.r1 * tau2_q;
      s7_den_q     <= s6_den_q;
      s7_side_q    <= s6_side_q;

      side_q[0] <= s7_side_q;
      for (int k = 1; k < QB; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  skf_div u_div1 (.clk_i(clk_i), .en_i(en), .num_i(s7_n1_q), .den_i(s7_den_q), .quo_o(q1));
  skf_div u_div2 (.clk_i(clk_i), .en_i(en), .num_i(s7_n2_q), .den_i(s7_den_q), .quo_o(q2));
  skf_div u_divv (.clk_i(clk_i), .en_i(en), .num_i(s7_nv_q), .den_i(s7_den_q), .quo_o(qv));

  // zero denominator means zero gain
  always_comb begin
    fin_t f;
    f = side_q[QB-1];
    res_o.comp = f.comp;
    res_o.pm1  = f.p1;
    res_o.pm2  = f.p2;
    res_o.pv   = f.r1;
    res_o.fm1  = f.dz ? f.p1 : sat_wide(sx(f.p1) + (f.neg1 ? -ux(q1) : ux(q1)));
    res_o.fm2  = f.dz ? f.p2 : sat_wide(sx(f.p2) + (f.neg2 ? -ux(q2) : ux(q2)));
    res_o.fv   = f.dz ? f.r1 : qv[VW-1:0];
  end

  assign res_valid_o = wb;

endmodule

// ===== hdl/spectral_kalman_filter_bank.sv =====
// an accepted step leaves its result in the result queue on the output side
// throughput: one item per cycle unless the result queue is full; a step waits at the
// head of the internal queue while a step to the same component is still in the 40-stage pipeline
// loads write the coefficient memories when they issue and give no result
// reset clears queues, pipeline valids and busy flags; obs_noise_var resets to 1.0
// coefficient and state memories are not cleared and hold garbage until written
module spectral_kalman_filter_bank import skf_pkg::*; #(
  parameter int MAX_COMPONENTS = MAX_COMP_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 obs_noise_var_we_i,
  input  logic [VW-1:0]        obs_noise_var_i,
  input  logic                 push,
  output logic                 full,
  input  logic                 operation_i,
  input  logic [CW-1:0]        component_i,
  input  logic                 is_pair_i,
  input  logic signed [DW-1:0] coef_damp_cos_i,
  input  logic signed [DW-1:0] coef_damp_sin_i,
  input  logic [VW-1:0]        coef_spectrum_i,
  input  logic                 first_step_i,
  input  logic signed [DW-1:0] obs_first_i,
  input  logic signed [DW-1:0] obs_second_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [CW-1:0]        out_component_o,
  output logic signed [DW-1:0] pred_mean_first_o,
  output logic signed [DW-1:0] pred_mean_second_o,
  output logic [VW-1:0]        pred_variance_o,
  output logic signed [DW-1:0] filt_mean_first_o,
  output logic signed [DW-1:0] filt_mean_second_o,
  output logic [VW-1:0]        filt_variance_o
);

  item_t head;
  logic  head_valid, head_pop;
  logic  res_valid, res_full;
  res_t  res, out;

  skf_front #(.MAX_COMPONENTS(MAX_COMPONENTS)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .operation_i     (operation_i),
    .component_i     (component_i),
    .is_pair_i       (is_pair_i),
    .coef_damp_cos_i (coef_damp_cos_i),
    .coef_damp_sin_i (coef_damp_sin_i),
    .coef_spectrum_i (coef_spectrum_i),
    .first_step_i    (first_step_i),
    .obs_first_i     (obs_first_i),
    .obs_second_i    (obs_second_i),
    .head_o          (head),
    .head_valid_o    (head_valid),
    .head_pop_i      (head_pop)
  );

  skf_back #(.MAX_COMPONENTS(MAX_COMPONENTS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tau2_we_i    (obs_noise_var_we_i),
    .tau2_i       (obs_noise_var_i),
    .head_i       (head),
    .head_valid_i (head_valid),
    .head_pop_o   (head_pop),
    .res_full_i   (res_full),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  skf_queue #(.T(res_t), .DEPTH(RES_DEPTH)) u_res (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out),
    .empty_o (empty)
  );

  assign out_component_o    = out.comp;
  assign pred_mean_first_o  = out.pm1;
  assign pred_mean_second_o = out.pm2;
  assign pred_variance_o    = out.pv;
  assign filt_mean_first_o  = out.fm1;
  assign filt_mean_second_o = out.fm2;
  assign filt_variance_o    = out.fv;

endmodule

// ===== hdl/skf_checker.sv =====
// port-level checks for the filter bank, bound to the top level
// depends on skf_pkg and assert_macros.svh
`include "assert_macros.svh"

module skf_checker import skf_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 full,
  input logic                 empty,
  input logic                 pop,
  input logic [CW-1:0]        out_component_o,
  input logic [VW-1:0]        pred_variance_o,
  input logic [VW-1:0]        filt_variance_o
);

  // the update never raises the variance
  `SKF_ASSERT(a_var_shrinks, clk_i, rst_ni, !empty |-> filt_variance_o <= pred_variance_o)

  // a reset edge leaves both sides idle
  `SKF_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> empty && !full)

  // a result that is not taken stays put
  `SKF_ASSERT(a_res_hold, clk_i, rst_ni,
              !empty && !pop |=> !empty && $stable(out_component_o) && $stable(filt_variance_o))

endmodule

bind spectral_kalman_filter_bank skf_checker u_skf_checker (.*);
